// ===== sv/criu_pkg.sv =====
// Shared types and constants for the config register instruction unit.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package criu_pkg;

    // Payload field widths
    localparam int OPCODE_W = 3;
    localparam int THREAD_W = 2;
    localparam int CFGIDX_W = 8;
    localparam int GPRIDX_W = 6;
    localparam int THDIDX_W = 6;
    localparam int LANE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 1;

    typedef logic [OPCODE_W-1:0]   opcode_t;
    typedef logic [CFG_ADDR_W-1:0] reg_index_t;

    // Opcodes
    localparam opcode_t OP_SET16  = 3'd0;
    localparam opcode_t OP_CFG_WR = 3'd1;
    localparam opcode_t OP_CFG_RD = 3'd2;
    localparam opcode_t OP_RMW    = 3'd3;
    localparam opcode_t OP_GPR_LD = 3'd4;
    localparam opcode_t OP_GPR_RD = 3'd5;
    localparam opcode_t OP_THD_RD = 3'd6;

    // Configuration register indexes
    localparam reg_index_t REG_BANK_T0 = 2'd0;
    localparam reg_index_t REG_BANK_T1 = 2'd1;
    localparam reg_index_t REG_BANK_T2 = 2'd2;

    localparam logic [WORD_W-1:0] HALF_MASK = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] BYTE_MASK = 32'h0000_00FF;

endpackage : criu_pkg

`default_nettype wire

// ===== sv/criu_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies; used for the config store, thread regs and GPR file.
`timescale 1ns / 1ps
`default_nettype none

module criu_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule : criu_ram

`default_nettype wire

// ===== sv/config_register_instruction_unit.sv =====
// Config register instruction unit: sequencer, decode and the three stores.
// Depends on criu_pkg and criu_ram.
`timescale 1ns / 1ps
`default_nettype none

// Executes config-register instructions for THREADS hardware threads. Each
// thread addresses one of BANKS config banks (CFG_REGS x 32 bits) chosen by
// its bank register, plus its own THD_REGS x 16-bit control registers and
// GPRS x 32-bit general registers. All three stores are single-write,
// registered-read RAMs, and every instruction runs through the same
// read / execute / retire sequence around them, so the unit handles one
// transaction at a time. From acceptance a transaction passes through the
// read, execute and retire steps until s_ready returns (result registered
// in m_* on the way); a four-word copy goes back through the read and
// execute steps for each further word, as the GPR file has a single read
// port. If the previous result is still waiting on m_ready, the retire
// step holds and s_ready returns that much later. After reset the unit
// sweeps all stores to zero, one entry per cycle, through every entry of
// the largest store ({bank|thread, index} with each index padded to a
// power of two). s_ready stays low meanwhile, while bank register writes
// are taken at any time. Bank registers are written
// through cfg_wen / cfg_waddr / cfg_wdata and must only change while idle.
// Every input transaction returns exactly one result: m_read_data carries the
// value for the read opcodes (zero otherwise), and m_status flags a four-word
// copy that would run past the bank end and was dropped.
module config_register_instruction_unit
    import criu_pkg::*;
#(
    parameter int CFG_REGS = 256,
    parameter int THD_REGS = 64,
    parameter int GPRS     = 64,
    parameter int THREADS  = 3,
    parameter int BANKS    = 2
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Bank register write port
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0] cfg_waddr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // Instruction channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OPCODE_W-1:0]   s_opcode,
    input  wire logic [THREAD_W-1:0]   s_thread,
    input  wire logic [CFGIDX_W-1:0]   s_cfg_index,
    input  wire logic [GPRIDX_W-1:0]   s_gpr_index,
    input  wire logic [THDIDX_W-1:0]   s_thd_index,
    input  wire logic [LANE_W-1:0]     s_byte_lane,
    input  wire logic [BYTE_W-1:0]     s_mask_byte,
    input  wire logic [BYTE_W-1:0]     s_data_byte,
    input  wire logic [WORD_W-1:0]     s_write_value,
    input  wire logic                  s_wide_write,

    // Result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [WORD_W-1:0]     m_read_data,
    output logic                       m_status
);

    // ------------------------------------------------------------------
    // Geometry. Stores are addressed {bank|thread, index}, each index
    // field padded to a power of two.
    // ------------------------------------------------------------------
    localparam int CFG_AW    = (CFG_REGS > 1) ? $clog2(CFG_REGS) : 1;
    localparam int BW        = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int TW        = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int GPR_AW    = (GPRS > 1) ? $clog2(GPRS) : 1;
    localparam int THD_AW    = (THD_REGS > 1) ? $clog2(THD_REGS) : 1;

    localparam int CFG_MAW   = BW + CFG_AW;
    localparam int GPR_MAW   = TW + GPR_AW;
    localparam int THD_MAW   = TW + THD_AW;
    localparam int CFG_DEPTH = BANKS << CFG_AW;
    localparam int GPR_DEPTH = THREADS << GPR_AW;
    localparam int THD_DEPTH = THREADS << THD_AW;

    localparam int CLR_W0    = (CFG_MAW > GPR_MAW) ? CFG_MAW : GPR_MAW;
    localparam int CLR_W     = (CLR_W0 > THD_MAW) ? CLR_W0 : THD_MAW;
    localparam int CLR_D0    = (CFG_DEPTH > GPR_DEPTH) ? CFG_DEPTH : GPR_DEPTH;
    localparam int CLR_DEPTH = (CLR_D0 > THD_DEPTH) ? CLR_D0 : THD_DEPTH;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // zeroing sweep after reset
    localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for an instruction
    localparam logic [2:0] ST_READ  = 3'd2;  // RAM reads in flight
    localparam logic [2:0] ST_EXEC  = 3'd3;  // read data back, do the write
    localparam logic [2:0] ST_FIN   = 3'd4;  // hand result to output reg

    // GPR index modulo GPRS: restoring subtract of GPRS << j, six steps
    function automatic logic [GPR_AW-1:0] gpr_mod(input logic [GPRIDX_W-1:0] v);
        logic [13:0] x;
        x = {8'd0, v};
        for (int j = GPRIDX_W - 1; j >= 0; j--) begin
            if (x >= (14'(GPRS) << j)) begin
                x = x - (14'(GPRS) << j);
            end
        end
        return GPR_AW'(x);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]          state_reg, state_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                bank_t0_reg, bank_t1_reg, bank_t2_reg;

    // Latched instruction
    logic [OPCODE_W-1:0] op_reg;
    logic                thr_ok_reg;
    logic [TW-1:0]       thr_reg;
    logic [BW-1:0]       bank_reg;
    logic                ci_ok_reg;
    logic                wide_reg;
    logic                wide_ok_reg;
    logic                ti_ok_reg;
    logic [THD_AW-1:0]   ti_reg;
    logic [GPR_AW-1:0]   gi_reg, gi_next;
    logic [CFG_AW-1:0]   ofs_reg, ofs_next;
    logic [1:0]          word_reg, word_next;
    logic [LANE_W-1:0]   lane_reg;
    logic [BYTE_W-1:0]   mask_reg;
    logic [BYTE_W-1:0]   data_reg;
    logic [WORD_W-1:0]   wv_reg;
    logic                st_reg;
    logic [WORD_W-1:0]   rd_reg, rd_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]   m_read_data_reg;
    logic                m_status_reg;

    // ------------------------------------------------------------------
    // Decode of the incoming transaction
    // ------------------------------------------------------------------
    logic                in_accept;
    logic                in_thr_ok;
    logic [0:0]          in_bank_raw;
    logic [BW-1:0]       in_bank;
    logic                in_ci_ok;
    logic                in_wide_ok;
    logic                in_ti_ok;
    logic                in_status;

    assign in_accept  = s_valid && s_ready;
    assign in_thr_ok  = {2'b00, s_thread} < 4'(THREADS);
    assign in_ci_ok   = {6'd0, s_cfg_index} < 14'(CFG_REGS);
    assign in_wide_ok = ({6'd0, s_cfg_index} + 14'd3) < 14'(CFG_REGS);
    assign in_ti_ok   = {5'd0, s_thd_index} < 11'(THD_REGS);
    assign in_status  = in_thr_ok && (s_opcode == OP_CFG_WR) && s_wide_write &&
                        !in_wide_ok;

    // Threads without a bank register use bank 0
    always_comb begin
        case (s_thread)
            2'd0:    in_bank_raw = bank_t0_reg;
            2'd1:    in_bank_raw = bank_t1_reg;
            2'd2:    in_bank_raw = bank_t2_reg;
            default: in_bank_raw = 1'b0;
        endcase
    end

    // Bank value taken modulo BANKS: a single bank swallows the bit
    assign in_bank = (BANKS > 1) ? BW'(in_bank_raw) : BW'(0);

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    logic               cs_we;
    logic [CFG_MAW-1:0] cs_waddr, cs_raddr;
    logic [WORD_W-1:0]  cs_wdata, cs_rdata;
    logic               gp_we;
    logic [GPR_MAW-1:0] gp_waddr, gp_raddr;
    logic [WORD_W-1:0]  gp_wdata, gp_rdata;
    logic               tc_we;
    logic [THD_MAW-1:0] tc_waddr, tc_raddr;
    logic [HALF_W-1:0]  tc_wdata, tc_rdata;

    assign cs_raddr = {bank_reg, ofs_reg};
    assign gp_raddr = {thr_reg, gi_reg};
    assign tc_raddr = {thr_reg, ti_reg};

    criu_ram #(.DEPTH(CFG_DEPTH), .AW(CFG_MAW), .DW(WORD_W)) u_cfg_store (
        .aclk  (aclk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .raddr (cs_raddr),
        .rdata (cs_rdata)
    );

    criu_ram #(.DEPTH(GPR_DEPTH), .AW(GPR_MAW), .DW(WORD_W)) u_gpr_file (
        .aclk  (aclk),
        .we    (gp_we),
        .waddr (gp_waddr),
        .wdata (gp_wdata),
        .raddr (gp_raddr),
        .rdata (gp_rdata)
    );

    criu_ram #(.DEPTH(THD_DEPTH), .AW(THD_MAW), .DW(HALF_W)) u_thd_regs (
        .aclk  (aclk),
        .we    (tc_we),
        .waddr (tc_waddr),
        .wdata (tc_wdata),
        .raddr (tc_raddr),
        .rdata (tc_rdata)
    );

    // ------------------------------------------------------------------
    // Execute unit: byte-lane merge and wide-copy index stepping
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]   lane_mask;
    logic [WORD_W-1:0]   lane_data;
    logic [WORD_W-1:0]   rmw_word;
    logic [GPR_AW:0]     gi_inc;
    logic [GPR_AW-1:0]   gi_wrap;
    logic                clr_last;

    assign lane_mask = ((WORD_W'(mask_reg)) & BYTE_MASK) << {lane_reg, 3'b000};
    assign lane_data = ((WORD_W'(data_reg)) & BYTE_MASK) << {lane_reg, 3'b000};
    assign rmw_word  = (cs_rdata & ~lane_mask) | (lane_data & lane_mask);

    assign gi_inc  = {1'b0, gi_reg} + 1'b1;
    assign gi_wrap = (gi_inc == (GPR_AW + 1)'(GPRS)) ? GPR_AW'(0) : gi_inc[GPR_AW-1:0];

    assign clr_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        gi_next      = gi_reg;
        ofs_next     = ofs_reg;
        word_next    = word_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg && !m_ready;

        cs_we    = 1'b0;
        cs_waddr = {bank_reg, ofs_reg};
        cs_wdata = gp_rdata;
        gp_we    = 1'b0;
        gp_waddr = {thr_reg, gi_reg};
        gp_wdata = wv_reg;
        tc_we    = 1'b0;
        tc_waddr = {thr_reg, ti_reg};
        tc_wdata = HALF_W'(wv_reg & HALF_MASK);

        case (state_reg)
            ST_CLEAR: begin
                cs_we    = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(CFG_DEPTH);
                cs_waddr = clr_cnt_reg[CFG_MAW-1:0];
                cs_wdata = '0;
                gp_we    = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(GPR_DEPTH);
                gp_waddr = clr_cnt_reg[GPR_MAW-1:0];
                gp_wdata = '0;
                tc_we    = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(THD_DEPTH);
                tc_waddr = clr_cnt_reg[THD_MAW-1:0];
                tc_wdata = '0;
                if (clr_last) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    gi_next    = gpr_mod(s_gpr_index);
                    ofs_next   = CFG_AW'({6'd0, s_cfg_index});
                    word_next  = 2'd0;
                    rd_next    = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_FIN;
                if (thr_ok_reg) begin
                    case (op_reg)
                        OP_SET16: begin
                            tc_we = ti_ok_reg;
                        end
                        OP_CFG_WR: begin
                            if (wide_reg) begin
                                cs_we = wide_ok_reg;
                                // step to the next word pair until four are done
                                if (wide_ok_reg && (word_reg != 2'd3)) begin
                                    word_next  = word_reg + 1'b1;
                                    ofs_next   = ofs_reg + 1'b1;
                                    gi_next    = gi_wrap;
                                    state_next = ST_READ;
                                end
                            end else begin
                                cs_we = ci_ok_reg;
                            end
                        end
                        OP_CFG_RD: begin
                            rd_next  = ci_ok_reg ? cs_rdata : '0;
                            gp_we    = 1'b1;
                            gp_wdata = ci_ok_reg ? cs_rdata : '0;
                        end
                        OP_RMW: begin
                            cs_we    = ci_ok_reg;
                            cs_wdata = rmw_word;
                        end
                        OP_GPR_LD: begin
                            gp_we = 1'b1;
                        end
                        OP_GPR_RD: begin
                            rd_next = gp_rdata;
                        end
                        OP_THD_RD: begin
                            rd_next = ti_ok_reg ? WORD_W'(tc_rdata) : '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            bank_t0_reg <= 1'b0;
            bank_t1_reg <= 1'b0;
            bank_t2_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                case (cfg_waddr)
                    REG_BANK_T0: bank_t0_reg <= cfg_wdata[0];
                    REG_BANK_T1: bank_t1_reg <= cfg_wdata[0];
                    REG_BANK_T2: bank_t2_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        gi_reg   <= gi_next;
        ofs_reg  <= ofs_next;
        word_reg <= word_next;
        rd_reg   <= rd_next;
        if (in_accept) begin
            op_reg      <= s_opcode;
            thr_ok_reg  <= in_thr_ok;
            thr_reg     <= in_thr_ok ? TW'({2'b00, s_thread}) : TW'(0);
            bank_reg    <= in_bank;
            ci_ok_reg   <= in_ci_ok;
            wide_reg    <= s_wide_write;
            wide_ok_reg <= in_wide_ok;
            ti_ok_reg   <= in_ti_ok;
            ti_reg      <= THD_AW'({5'd0, s_thd_index});
            lane_reg    <= s_byte_lane;
            mask_reg    <= s_mask_byte;
            data_reg    <= s_data_byte;
            wv_reg      <= s_write_value;
            st_reg      <= in_status;
        end
        if ((state_reg == ST_FIN) && (!m_valid_reg || m_ready)) begin
            m_read_data_reg <= rd_reg;
            m_status_reg    <= st_reg;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;

endmodule : config_register_instruction_unit

`default_nettype wire

// ===== sv/criu_checker.sv =====
// Port-level checks for the config register instruction unit, bound to it.
// Depends on criu_pkg and config_register_instruction_unit.
`timescale 1ns / 1ps
`default_nettype none

module criu_checker
    import criu_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [WORD_W-1:0]     m_read_data,
    input wire logic                  m_status
);

    // Reset holds off both channels (stores are swept first)
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("channel active right after reset");

    // One transaction at a time: ready drops after each acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second transaction while busy");

    // A dropped four-word copy returns no read data
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_read_data == '0)
        else $error("status set with nonzero read data");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_status))
        else $error("result changed while stalled");

endmodule : criu_checker

bind config_register_instruction_unit criu_checker u_criu_checker (.*);

`default_nettype wire

// ===== dv/config_register_instruction_unit_tb.sv =====
// Testbench for config_register_instruction_unit: directed and random instruction
// streams, a predictor built on the stores in the testbench, and a result checker.
// Depends on criu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module config_register_instruction_unit_tb;
    import criu_pkg::*;

    // Same sizes as the unit's defaults, passed explicitly below
    localparam int N_CFG     = 256;
    localparam int N_THD     = 64;
    localparam int N_GPRS    = 64;
    localparam int N_THREADS = 3;
    localparam int N_BANKS   = 2;

    // A handshake-free cycle count longer than any correct run can produce: the
    // zeroing sweep after reset, plus the longest sender gap, a four-word copy
    // and the longest receiver stall.
    localparam int LIMIT_CYCLES = 4000;
    // Cycles left for the unit to retire its last transaction before the
    // bank registers change or the run ends.
    localparam int SETTLE       = 20;
    localparam int PHASE_ITEMS  = 360;

    typedef struct {
        opcode_t             opcode;
        logic [THREAD_W-1:0] thread;
        logic [CFGIDX_W-1:0] cfg_index;
        logic [GPRIDX_W-1:0] gpr_index;
        logic [THDIDX_W-1:0] thd_index;
        logic [LANE_W-1:0]   byte_lane;
        logic [BYTE_W-1:0]   mask_byte;
        logic [BYTE_W-1:0]   data_byte;
        logic [WORD_W-1:0]   write_value;
        logic                wide_write;
    } instr_t;

    typedef struct {
        logic [WORD_W-1:0] read_data;
        logic              status;
    } result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wen;
    logic [CFG_ADDR_W-1:0] cfg_waddr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [OPCODE_W-1:0]   s_opcode;
    logic [THREAD_W-1:0]   s_thread;
    logic [CFGIDX_W-1:0]   s_cfg_index;
    logic [GPRIDX_W-1:0]   s_gpr_index;
    logic [THDIDX_W-1:0]   s_thd_index;
    logic [LANE_W-1:0]     s_byte_lane;
    logic [BYTE_W-1:0]     s_mask_byte;
    logic [BYTE_W-1:0]     s_data_byte;
    logic [WORD_W-1:0]     s_write_value;
    logic                  s_wide_write;
    logic                  m_valid;
    logic                  m_ready;
    logic [WORD_W-1:0]     m_read_data;
    logic                  m_status;

    // Shadow copies of the unit's state, updated as each transaction is accepted
    logic [WORD_W-1:0]     cfg_shadow  [N_BANKS][N_CFG];
    logic [HALF_W-1:0]     ctrl_shadow [N_THREADS][N_THD];
    logic [WORD_W-1:0]     gpr_shadow  [N_THREADS][N_GPRS];
    logic [CFG_DATA_W-1:0] bank_sel    [N_THREADS];

    result_t pending_results[$];
    int      errors     = 0;
    int      items_sent = 0;
    int      idle_count = 0;
    bit      src_idle   = 1'b1;  // sender inserts gaps
    bit      sink_idle  = 1'b1;  // receiver stalls
    int      hot_base   = 0;     // cfg window most traffic lands in

    config_register_instruction_unit #(
        .CFG_REGS (N_CFG),
        .THD_REGS (N_THD),
        .GPRS     (N_GPRS),
        .THREADS  (N_THREADS),
        .BANKS    (N_BANKS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_waddr     (cfg_waddr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_thread      (s_thread),
        .s_cfg_index   (s_cfg_index),
        .s_gpr_index   (s_gpr_index),
        .s_thd_index   (s_thd_index),
        .s_byte_lane   (s_byte_lane),
        .s_mask_byte   (s_mask_byte),
        .s_data_byte   (s_data_byte),
        .s_write_value (s_write_value),
        .s_wide_write  (s_wide_write),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [CFGIDX_W-1:0] pick_cfg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return CFGIDX_W'((hot_base + $urandom_range(0, 15)) & 8'hFF);
        if (r < 80) return CFGIDX_W'($urandom_range(248, 255));
        return CFGIDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [GPRIDX_W-1:0] pick_small6();
        if ($urandom_range(0, 9) < 7) return GPRIDX_W'($urandom_range(0, 7));
        return GPRIDX_W'($urandom_range(0, 63));
    endfunction

    // Fully random transaction; callers override what matters
    function automatic instr_t mk(input opcode_t op, input int thread);
        instr_t ins;
        ins.opcode      = op;
        ins.thread      = THREAD_W'(thread);
        ins.cfg_index   = CFGIDX_W'($urandom);
        ins.gpr_index   = GPRIDX_W'($urandom);
        ins.thd_index   = THDIDX_W'($urandom);
        ins.byte_lane   = LANE_W'($urandom);
        ins.mask_byte   = BYTE_W'($urandom);
        ins.data_byte   = BYTE_W'($urandom);
        ins.write_value = $urandom;
        ins.wide_write  = 1'($urandom);
        return ins;
    endfunction

    // Predicts the result of one transaction and applies its side effects
    // to the shadow stores.
    function automatic result_t exec_instr(input instr_t ins);
        result_t           r;
        int                t, b, ci, gi, ti, k, shift;
        logic [WORD_W-1:0] m, d;
        r.read_data = '0;
        r.status    = 1'b0;
        t  = ins.thread;
        ci = ins.cfg_index;
        gi = ins.gpr_index % N_GPRS;
        ti = ins.thd_index;
        // Threads with no hardware behind them do nothing at all
        if (t < N_THREADS) begin
            b = bank_sel[t] % N_BANKS;
            case (ins.opcode)
                OP_SET16: begin
                    if (ti < N_THD)
                        ctrl_shadow[t][ti] = HALF_W'(ins.write_value & HALF_MASK);
                end
                OP_CFG_WR: begin
                    if (ins.wide_write) begin
                        // Four-word copy running off the bank end is dropped
                        if (ci + 3 < N_CFG) begin
                            for (k = 0; k < 4; k++)
                                cfg_shadow[b][ci + k] = gpr_shadow[t][(gi + k) % N_GPRS];
                        end else begin
                            r.status = 1'b1;
                        end
                    end else if (ci < N_CFG) begin
                        cfg_shadow[b][ci] = gpr_shadow[t][gi];
                    end
                end
                OP_CFG_RD: begin
                    r.read_data = (ci < N_CFG) ? cfg_shadow[b][ci] : '0;
                    gpr_shadow[t][gi] = r.read_data;
                end
                OP_RMW: begin
                    if (ci < N_CFG) begin
                        shift = ins.byte_lane * BYTE_W;
                        m = ({24'd0, ins.mask_byte} & BYTE_MASK) << shift;
                        d = ({24'd0, ins.data_byte} & BYTE_MASK) << shift;
                        cfg_shadow[b][ci] = (cfg_shadow[b][ci] & ~m) | (d & m);
                    end
                end
                OP_GPR_LD: gpr_shadow[t][gi] = ins.write_value;
                OP_GPR_RD: r.read_data = gpr_shadow[t][gi];
                OP_THD_RD: begin
                    if (ti < N_THD) r.read_data = {16'd0, ctrl_shadow[t][ti]};
                end
                default: ;  // unused opcode: no effect, zero result
            endcase
        end
        return r;
    endfunction

    // Input monitor and result checker share one process so the expectation
    // queue is touched in a fixed order within each edge.
    always @(posedge aclk) begin
        result_t want;
        instr_t  got_in;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                got_in.opcode      = s_opcode;
                got_in.thread      = s_thread;
                got_in.cfg_index   = s_cfg_index;
                got_in.gpr_index   = s_gpr_index;
                got_in.thd_index   = s_thd_index;
                got_in.byte_lane   = s_byte_lane;
                got_in.mask_byte   = s_mask_byte;
                got_in.data_byte   = s_data_byte;
                got_in.write_value = s_write_value;
                got_in.wide_write  = s_wide_write;
                pending_results.push_back(exec_instr(got_in));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected: read_data %h status %b",
                             $realtime, m_read_data, m_status);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_read_data !== want.read_data) begin
                        $display("%0t: read_data mismatch: expected %h actual %h",
                                 $realtime, want.read_data, m_read_data);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch: expected %b actual %b",
                                 $realtime, want.status, m_status);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: any handshake on either channel restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= LIMIT_CYCLES) begin
            $display("watchdog expired at %0t", $realtime);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // Receiver: random stalls while sink_idle is set, otherwise always ready
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if (sink_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Drives one transaction; called at a falling edge, returns at one.
    // Valid stays high afterwards unless a gap is inserted.
    task automatic send_instr(input instr_t ins);
        int gap;
        s_opcode      = ins.opcode;
        s_thread      = ins.thread;
        s_cfg_index   = ins.cfg_index;
        s_gpr_index   = ins.gpr_index;
        s_thd_index   = ins.thd_index;
        s_byte_lane   = ins.byte_lane;
        s_mask_byte   = ins.mask_byte;
        s_data_byte   = ins.data_byte;
        s_write_value = ins.write_value;
        s_wide_write  = ins.wide_write;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Drop valid and wait until every result is back and the unit has retired
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_bank(input reg_index_t idx, input logic val);
        cfg_wen   = 1'b1;
        cfg_waddr = idx;
        cfg_wdata = val;
        bank_sel[idx] = val;
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    task automatic set_banks(input logic b0, input logic b1, input logic b2);
        wait_idle();
        write_bank(REG_BANK_T0, b0);
        write_bank(REG_BANK_T1, b1);
        write_bank(REG_BANK_T2, b2);
    endtask

    // Hand-picked transactions: reset contents, index extremes, every opcode,
    // unused opcode, missing thread, four-word copy at and past the bank end,
    // general-register wrap inside a four-word copy, set16 dropping high bits.
    task automatic test_directed();
        instr_t ins;
        ins = mk(OP_GPR_RD, 0); ins.gpr_index = 6'd63;  send_instr(ins);
        ins = mk(OP_THD_RD, 2); ins.thd_index = 6'd63;  send_instr(ins);
        ins = mk(OP_CFG_RD, 1); ins.cfg_index = 8'd255; ins.gpr_index = 6'd5; send_instr(ins);
        ins = mk(OP_GPR_LD, 0); ins.gpr_index = 6'd63; ins.write_value = 32'hFFFF_FFFF;
        send_instr(ins);
        ins = mk(OP_GPR_LD, 0); ins.gpr_index = 6'd62; ins.write_value = 32'h0000_0001;
        send_instr(ins);
        ins = mk(OP_GPR_LD, 0); ins.gpr_index = 6'd0;  ins.write_value = 32'h1234_5678;
        send_instr(ins);
        ins = mk(OP_GPR_LD, 0); ins.gpr_index = 6'd1;  ins.write_value = 32'hA5A5_A5A5;
        send_instr(ins);
        // Last legal four-word copy; GPR indexes wrap 62, 63, 0, 1
        ins = mk(OP_CFG_WR, 0); ins.wide_write = 1'b1; ins.cfg_index = 8'd252;
        ins.gpr_index = 6'd62; send_instr(ins);
        ins = mk(OP_CFG_WR, 0); ins.wide_write = 1'b1; ins.cfg_index = 8'd253; send_instr(ins);
        ins = mk(OP_CFG_WR, 0); ins.wide_write = 1'b1; ins.cfg_index = 8'd255; send_instr(ins);
        ins = mk(OP_CFG_RD, 0); ins.cfg_index = 8'd255; ins.gpr_index = 6'd10; send_instr(ins);
        ins = mk(OP_CFG_WR, 0); ins.wide_write = 1'b0; ins.cfg_index = 8'd0;
        ins.gpr_index = 6'd63; send_instr(ins);
        ins = mk(OP_RMW, 0); ins.cfg_index = 8'd0; ins.byte_lane = 2'd3;
        ins.mask_byte = 8'hFF; ins.data_byte = 8'h00; send_instr(ins);
        ins = mk(OP_RMW, 0); ins.cfg_index = 8'd0; ins.byte_lane = 2'd0;
        ins.mask_byte = 8'h0F; ins.data_byte = 8'hA5; send_instr(ins);
        ins = mk(OP_RMW, 0); ins.cfg_index = 8'd0; ins.byte_lane = 2'd1;
        ins.mask_byte = 8'h00; ins.data_byte = 8'hFF; send_instr(ins);
        ins = mk(OP_RMW, 0); ins.cfg_index = 8'd0; ins.byte_lane = 2'd2;
        ins.mask_byte = 8'hAA; ins.data_byte = 8'h55; send_instr(ins);
        ins = mk(OP_CFG_RD, 0); ins.cfg_index = 8'd0; ins.gpr_index = 6'd3; send_instr(ins);
        ins = mk(OP_SET16, 1); ins.thd_index = 6'd63; ins.write_value = 32'hFFFF_ABCD;
        send_instr(ins);
        ins = mk(OP_THD_RD, 1); ins.thd_index = 6'd63; send_instr(ins);
        ins = mk(OP_SET16, 1); ins.thd_index = 6'd0; ins.write_value = 32'h0;
        send_instr(ins);
        ins = mk(opcode_t'(3'd7), 0); send_instr(ins);
        // Thread 3 has no state: load is dropped, read returns zero
        ins = mk(OP_GPR_LD, 3); ins.write_value = 32'hFFFF_FFFF; ins.gpr_index = 6'd7;
        send_instr(ins);
        ins = mk(OP_GPR_RD, 3); ins.gpr_index = 6'd7; send_instr(ins);
        ins = mk(OP_GPR_RD, 0); ins.gpr_index = 6'd10; send_instr(ins);
        // Thread 2 shares bank 0 with thread 0 here
        ins = mk(OP_CFG_RD, 2); ins.cfg_index = 8'd255; ins.gpr_index = 6'd0; send_instr(ins);
        wait_idle();
    endtask

    // A well-formed chain: fill GPRs, copy into config, maybe patch a byte,
    // read back through another GPR, and sometimes touch a control register.
    task automatic run_chain();
        instr_t ins;
        int     t, n, k;
        logic   wide;
        logic [GPRIDX_W-1:0] gi;
        logic [CFGIDX_W-1:0] ci;
        t    = $urandom_range(0, N_THREADS - 1);
        wide = ($urandom_range(0, 2) == 0);
        gi   = pick_small6();
        ci   = pick_cfg();
        n    = wide ? 4 : 1;
        for (k = 0; k < n; k++) begin
            ins = mk(OP_GPR_LD, t);
            ins.gpr_index = GPRIDX_W'(gi + k);
            send_instr(ins);
        end
        ins = mk(OP_CFG_WR, t);
        ins.wide_write = wide; ins.cfg_index = ci; ins.gpr_index = gi;
        send_instr(ins);
        if ($urandom_range(0, 1)) begin
            ins = mk(OP_RMW, t);
            ins.cfg_index = CFGIDX_W'(ci + $urandom_range(0, n - 1));
            send_instr(ins);
        end
        ins = mk(OP_CFG_RD, t);
        ins.cfg_index = CFGIDX_W'(ci + $urandom_range(0, n - 1));
        ins.gpr_index = pick_small6();
        send_instr(ins);
        gi = ins.gpr_index;
        ins = mk(OP_GPR_RD, t); ins.gpr_index = gi; send_instr(ins);
        if ($urandom_range(0, 3) == 0) begin
            ins = mk(OP_SET16, t); ins.thd_index = pick_small6(); send_instr(ins);
            gi  = ins.thd_index;
            ins = mk(OP_THD_RD, t); ins.thd_index = gi; send_instr(ins);
        end
    endtask

    // Unstructured traffic: any opcode including the unused one, any thread
    task automatic send_noise();
        instr_t ins;
        ins = mk(opcode_t'($urandom_range(0, 7)), $urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
            ins.cfg_index = pick_cfg();
            ins.gpr_index = pick_small6();
            ins.thd_index = pick_small6();
        end
        send_instr(ins);
    endtask

    task automatic test_random_mix(input int count);
        int target;
        target   = items_sent + count;
        hot_base = $urandom_range(0, 240);
        while (items_sent < target) begin
            if ($urandom_range(0, 3) == 0) send_noise();
            else run_chain();
        end
        wait_idle();
    endtask

    // Random traffic under one bank setting per phase, one phase without idling
    task automatic test_bank_settings();
        set_banks(1'b1, 1'b1, 1'b1);
        test_random_mix(PHASE_ITEMS);
        set_banks(1'b1, 1'b0, 1'b1);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_random_mix(PHASE_ITEMS);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        set_banks(1'b0, 1'b1, 1'b0);
        test_random_mix(PHASE_ITEMS);
        set_banks(1'b0, 1'b0, 1'b0);
        test_random_mix(PHASE_ITEMS);
        set_banks(1'b1, 1'b1, 1'b0);
        test_random_mix(PHASE_ITEMS);
    endtask

    initial begin
        foreach (cfg_shadow[i, j]) cfg_shadow[i][j] = '0;
        foreach (ctrl_shadow[i, j]) ctrl_shadow[i][j] = '0;
        foreach (gpr_shadow[i, j]) gpr_shadow[i][j] = '0;
        foreach (bank_sel[i]) bank_sel[i] = '0;
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_waddr     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_opcode      = '0;
        s_thread      = '0;
        s_cfg_index   = '0;
        s_gpr_index   = '0;
        s_thd_index   = '0;
        s_byte_lane   = '0;
        s_mask_byte   = '0;
        s_data_byte   = '0;
        s_write_value = '0;
        s_wide_write  = 1'b0;

        // Synchronous reset, released at a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The unit clears its stores after reset; the sender simply waits on
        // s_ready. Bank registers are accepted during the sweep.
        set_banks(1'b0, 1'b0, 1'b0);
        test_directed();
        test_bank_settings();

        wait_idle();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/criu_pkg.sv
sv/criu_ram.sv
sv/config_register_instruction_unit.sv
sv/criu_checker.sv
dv/config_register_instruction_unit_tb.sv
